FILE: hdl/dmgs_pkg.sv
package dmgs_pkg;

    // Fixed field widths
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_W       = 10;

    // Default size limits and reset frame size
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int MIN_SIZE       = 2;

    // Pixel codes
    localparam logic [PIX_W-1:0] PIX_MARK  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_EMPTY = 8'd0;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [OUT_W-1:0] start_x;
        logic [OUT_W-1:0] start_y;
        logic [OUT_W-1:0] end_x;
        logic [OUT_W-1:0] end_y;
        logic             ends_found;
        logic [OUT_W-1:0] center_x;
        logic [OUT_W-1:0] center_y;
    } result_t;

    // Clamp a requested frame size into [MIN_SIZE, maxv]
    function automatic int clamp_size(input int v, input int maxv);
        int r;
        r = v;
        if (v < MIN_SIZE)
        begin
            r = MIN_SIZE;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

FILE: hdl/dial_mask_geometry_scan_core.sv
// Result path: the last pixel of a frame passes the pixel input register, then the
// result register, before its frame result is offered.
// Throughput: 1 pixel per cycle; the scan stage updates all frame state per pixel.
// The output register holds a pending result while later pixels keep flowing; only
// the last pixel of the next frame waits for it to be taken.
// Reset: frame size 640 x 480 (clamped to MAX_WIDTH/MAX_HEIGHT), frame state cleared,
// no clearing pass; a size write also restarts the frame.
module dial_mask_geometry_scan_core #(
    parameter int MAX_WIDTH  = dmgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // pixel stream
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dmgs_pkg::PIX_W-1:0]       pixel,
    // frame results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dmgs_pkg::OUT_W-1:0]       start_x,
    output logic [dmgs_pkg::OUT_W-1:0]       start_y,
    output logic [dmgs_pkg::OUT_W-1:0]       end_x,
    output logic [dmgs_pkg::OUT_W-1:0]       end_y,
    output logic                             ends_found,
    output logic [dmgs_pkg::OUT_W-1:0]       center_x,
    output logic [dmgs_pkg::OUT_W-1:0]       center_y,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dmgs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dmgs_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT + 1);

    // Input stage: one pixel held for the scan stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [dmgs_pkg::PIX_W-1:0]  pixel_reg;

    // Output stage: one finished frame result
    logic                        out_valid_reg;
    logic                        out_valid_next;
    dmgs_pkg::result_t           result_reg;

    logic [CW-1:0]               width_eff;
    logic [CH-1:0]               height_eff;
    logic                        restart;
    logic                        frame_done;
    dmgs_pkg::result_t           result;
    logic                        out_free;
    logic                        advance;
    logic                        load_out;

    // Retire the held pixel unless it closes the frame and the result slot is busy
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && (!frame_done || out_free);
    assign load_out = advance && frame_done;
    assign in_ready = !s1_valid_reg || advance;

    // Take size writes only with no pixel in flight
    assign cfg_ready = !s1_valid_reg;

    dmgs_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (cfg_valid && cfg_ready),
        .write_index (cfg_index),
        .write_data  (cfg_data),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .restart     (restart)
    );

    dmgs_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .restart    (restart),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .pixel      (pixel_reg),
        .frame_done (frame_done),
        .result     (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold until the next transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pixel_reg <= pixel;
        end
        if (load_out)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_x    = result_reg.start_x;
    assign start_y    = result_reg.start_y;
    assign end_x      = result_reg.end_x;
    assign end_y      = result_reg.end_y;
    assign ends_found = result_reg.ends_found;
    assign center_x   = result_reg.center_x;
    assign center_y   = result_reg.center_y;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("frame result lost at output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("pending frame result overwritten");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (s1_valid_reg == $past(in_valid && in_ready)))
        else $error("size write overlapped a pixel in flight");

endmodule

FILE: hdl/dmgs_cfg.sv
module dmgs_cfg #(
    parameter int MAX_WIDTH  = dmgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_en,
    input  logic [dmgs_pkg::CFG_INDEX_W-1:0]    write_index,
    input  logic [dmgs_pkg::CFG_W-1:0]          write_data,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
    output logic                                restart
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int CH = $clog2(MAX_HEIGHT + 1);

    localparam logic [CW-1:0] WIDTH_RST =
        CW'(dmgs_pkg::clamp_size(dmgs_pkg::RESET_WIDTH, MAX_WIDTH));
    localparam logic [CH-1:0] HEIGHT_RST =
        CH'(dmgs_pkg::clamp_size(dmgs_pkg::RESET_HEIGHT, MAX_HEIGHT));

    logic [CW-1:0] width_reg;
    logic [CW-1:0] width_next;
    logic [CH-1:0] height_reg;
    logic [CH-1:0] height_next;
    logic          hit;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        hit         = 1'b0;
        unique case (write_index)
            dmgs_pkg::REG_FRAME_WIDTH:
            begin
                hit        = write_en;
                width_next = CW'(dmgs_pkg::clamp_size(int'(write_data), MAX_WIDTH));
            end
            dmgs_pkg::REG_FRAME_HEIGHT:
            begin
                hit         = write_en;
                height_next = CH'(dmgs_pkg::clamp_size(int'(write_data), MAX_HEIGHT));
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (hit)
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign width_eff  = width_reg;
    assign height_eff = height_reg;
    assign restart    = hit;

endmodule

FILE: hdl/dmgs_scan.sv
module dmgs_scan #(
    parameter int MAX_WIDTH  = dmgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dmgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height_eff,
    input  logic [dmgs_pkg::PIX_W-1:0]          pixel,
    output logic                                frame_done,
    output dmgs_pkg::result_t                   result
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CH = $clog2(MAX_HEIGHT + 1);

    // Column and row position; rows are counted up from the top row
    logic [XW-1:0]        col_reg,         col_next;
    logic [YW-1:0]        rows_reg,        rows_next;
    logic [XW-1:0]        first_reg,       first_next;
    logic [XW-1:0]        last_reg,        last_next;
    logic                 has_mark_reg,    has_mark_next;
    logic signed [XW:0]   wspan_reg,       wspan_next;
    logic signed [XW:0]   wleft_reg,       wleft_next;
    logic signed [XW:0]   wright_reg,      wright_next;
    logic signed [YW:0]   band_last_reg,   band_last_next;
    logic signed [YW:0]   band_first_reg,  band_first_next;
    logic                 sfound_reg,      sfound_next;
    logic [XW-1:0]        sx_reg,          sx_next;
    logic [YW-1:0]        sy_reg,          sy_next;
    logic                 efound_reg,      efound_next;
    logic [XW-1:0]        ex_reg,          ex_next;
    logic [YW-1:0]        ey_reg,          ey_next;

    logic [XW:0]          col_plus;
    logic [XW:0]          w_ext;
    logic                 last_col;
    logic [CH-1:0]        h_less;
    logic [YW-1:0]        row_i;
    logic                 row_live;
    logic [XW-1:0]        mid;
    logic                 pix_hit;
    logic                 pix_nz;
    logic signed [XW:0]   left_s;
    logic signed [XW:0]   right_s;
    logic signed [XW:0]   span_s;
    logic                 take;
    logic                 ok;
    logic signed [XW+1:0] sum_x;
    logic signed [YW+1:0] sum_y;
    logic [XW:0]          cx_full;
    logic [YW:0]          cy_full;
    logic [31:0]          sx32, sy32, ex32, ey32, cx32, cy32;

    assign col_plus = {1'b0, col_reg} + 1'b1;
    assign w_ext    = (XW+1)'(width_eff);
    assign last_col = col_plus >= w_ext;
    assign h_less   = height_eff - CH'(1);
    assign row_i    = YW'(h_less - CH'(rows_reg));
    assign row_live = row_i != '0;
    assign mid      = XW'(width_eff >> 1);
    assign pix_hit  = pixel == dmgs_pkg::PIX_MARK;
    assign pix_nz   = pixel != dmgs_pkg::PIX_EMPTY;

    always_comb
    begin
        col_next        = col_reg;
        rows_next       = rows_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        has_mark_next   = has_mark_reg;
        wspan_next      = wspan_reg;
        wleft_next      = wleft_reg;
        wright_next     = wright_reg;
        band_last_next  = band_last_reg;
        band_first_next = band_first_reg;
        sfound_next     = sfound_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        efound_next     = efound_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;

        // Row 0 is taken in but never marks anything
        if (row_live && pix_hit && (col_reg < mid) && !sfound_reg)
        begin
            sfound_next = 1'b1;
            sx_next     = col_reg;
            sy_next     = row_i;
        end
        if (row_live && pix_hit && (col_reg > mid) && !efound_reg)
        begin
            efound_next = 1'b1;
            ex_next     = col_reg;
            ey_next     = row_i;
        end
        if (row_live && pix_nz)
        begin
            if (!has_mark_reg)
            begin
                first_next = col_reg;
            end
            last_next     = col_reg;
            has_mark_next = 1'b1;
        end

        // An empty row measures from the middle column outward
        if (has_mark_next)
        begin
            left_s  = signed'({1'b0, first_next});
            right_s = signed'({1'b0, last_next});
        end
        else
        begin
            left_s  = signed'({1'b0, mid});
            right_s = signed'(w_ext - (XW+1)'(1) - {1'b0, mid});
        end
        span_s = right_s - left_s;
        take   = wspan_reg <= span_s;

        if (!last_col)
        begin
            col_next = col_plus[XW-1:0];
        end
        else if (row_live)
        begin
            if (take)
            begin
                if (wspan_reg != span_s)
                begin
                    band_first_next = signed'({1'b0, row_i});
                end
                band_last_next = signed'({1'b0, row_i});
                wspan_next     = span_s;
                wleft_next     = left_s;
                wright_next    = right_s;
            end
            rows_next     = rows_reg + YW'(1);
            col_next      = '0;
            has_mark_next = 1'b0;
            first_next    = '0;
            last_next     = '0;
        end

        if (!step)
        begin
            col_next        = col_reg;
            rows_next       = rows_reg;
            first_next      = first_reg;
            last_next       = last_reg;
            has_mark_next   = has_mark_reg;
            wspan_next      = wspan_reg;
            wleft_next      = wleft_reg;
            wright_next     = wright_reg;
            band_last_next  = band_last_reg;
            band_first_next = band_first_reg;
            sfound_next     = sfound_reg;
            sx_next         = sx_reg;
            sy_next         = sy_reg;
            efound_next     = efound_reg;
            ex_next         = ex_reg;
            ey_next         = ey_reg;
        end

        // Drop all frame state at frame end or on a size register write
        if (restart || (step && last_col && !row_live))
        begin
            col_next        = '0;
            rows_next       = '0;
            first_next      = '0;
            last_next       = '0;
            has_mark_next   = 1'b0;
            wspan_next      = '1;
            wleft_next      = '1;
            wright_next     = '1;
            band_last_next  = '1;
            band_first_next = '1;
            sfound_next     = 1'b0;
            sx_next         = '0;
            sy_next         = '0;
            efound_next     = 1'b0;
            ex_next         = '0;
            ey_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            rows_reg       <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            has_mark_reg   <= 1'b0;
            wspan_reg      <= '1;
            wleft_reg      <= '1;
            wright_reg     <= '1;
            band_last_reg  <= '1;
            band_first_reg <= '1;
            sfound_reg     <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            efound_reg     <= 1'b0;
            ex_reg         <= '0;
            ey_reg         <= '0;
        end
        else
        begin
            col_reg        <= col_next;
            rows_reg       <= rows_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            has_mark_reg   <= has_mark_next;
            wspan_reg      <= wspan_next;
            wleft_reg      <= wleft_next;
            wright_reg     <= wright_next;
            band_last_reg  <= band_last_next;
            band_first_reg <= band_first_next;
            sfound_reg     <= sfound_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            efound_reg     <= efound_next;
            ex_reg         <= ex_next;
            ey_reg         <= ey_next;
        end
    end

    // Frame result, valid when the current pixel closes row 0
    assign frame_done = last_col && !row_live;
    assign ok         = sfound_reg && efound_reg && (sx_reg != '0) && (ex_reg != '0);
    assign sum_x      = {wleft_reg[XW], wleft_reg} + {wright_reg[XW], wright_reg};
    assign sum_y      = {band_last_reg[YW], band_last_reg} + {band_first_reg[YW], band_first_reg};
    assign cx_full    = sum_x[XW+1] ? '0 : sum_x[XW+1:1];
    assign cy_full    = sum_y[YW+1] ? '0 : sum_y[YW+1:1];
    assign sx32       = ok ? 32'(sx_reg) : '0;
    assign sy32       = ok ? 32'(sy_reg) : '0;
    assign ex32       = ok ? 32'(ex_reg) : '0;
    assign ey32       = ok ? 32'(ey_reg) : '0;
    assign cx32       = 32'(cx_full);
    assign cy32       = 32'(cy_full);

    assign result.start_x    = sx32[dmgs_pkg::OUT_W-1:0];
    assign result.start_y    = sy32[dmgs_pkg::OUT_W-1:0];
    assign result.end_x      = ex32[dmgs_pkg::OUT_W-1:0];
    assign result.end_y      = ey32[dmgs_pkg::OUT_W-1:0];
    assign result.ends_found = ok;
    assign result.center_x   = cx32[dmgs_pkg::OUT_W-1:0];
    assign result.center_y   = cy32[dmgs_pkg::OUT_W-1:0];

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_plus <= w_ext)
        else $error("column counter beyond frame width");

    a_start_left: assert property (@(posedge clk) disable iff (!rst_n)
        sfound_reg |-> (sx_reg < mid))
        else $error("start point not left of middle column");

    a_end_right: assert property (@(posedge clk) disable iff (!rst_n)
        efound_reg |-> (ex_reg > mid))
        else $error("end point not right of middle column");

endmodule

FILE: verif/dial_mask_geometry_scan_core_tb.sv
`timescale 1ns / 100ps

module dial_mask_geometry_scan_core_tb;

    localparam int MAX_W        = dmgs_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = dmgs_pkg::DEF_MAX_HEIGHT;
    localparam int LIMIT_CYCLES = 1_000_000;
    // The result passes the pixel and result registers after the last pixel; leave some margin
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_PIXELS = 200;
    localparam int MAX_REPORTS  = 40;

    typedef logic [dmgs_pkg::PIX_W-1:0] pix_t;
    typedef logic [dmgs_pkg::CFG_W-1:0] cfg_word_t;

    // Register indexes beyond the list; writes there must change nothing
    localparam logic [dmgs_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [dmgs_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [dmgs_pkg::PIX_W-1:0]       pixel;
    logic                             out_valid;
    logic                             out_ready;
    logic [dmgs_pkg::OUT_W-1:0]       start_x;
    logic [dmgs_pkg::OUT_W-1:0]       start_y;
    logic [dmgs_pkg::OUT_W-1:0]       end_x;
    logic [dmgs_pkg::OUT_W-1:0]       end_y;
    logic                             ends_found;
    logic [dmgs_pkg::OUT_W-1:0]       center_x;
    logic [dmgs_pkg::OUT_W-1:0]       center_y;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [dmgs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dmgs_pkg::CFG_W-1:0]       cfg_data;

    dial_mask_geometry_scan_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .ends_found (ends_found),
        .center_x   (center_x),
        .center_y   (center_y),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Scan predictor: mirrors the frame bookkeeping of the block
    // ------------------------------------------------------------------
    logic [dmgs_pkg::CFG_W-1:0] width_reg;
    logic [dmgs_pkg::CFG_W-1:0] height_reg;
    int               col_pos;
    int               row_pos;
    int               mark_lo;
    int               mark_hi;
    bit               row_marked;
    int               span_max;
    int               span_left;
    int               span_right;
    int               band_open;    // first (highest) row of the widest band
    int               band_close;   // last row that tied the widest span
    bit               start_seen;
    bit               end_seen;
    int               start_col;
    int               start_row;
    int               end_col;
    int               end_row;

    // Frame results still owed by the block, oldest first
    dmgs_pkg::result_t frames_due[$];

    // Stimulus knobs and bookkeeping
    int               in_gap_pct = 0;
    int               out_stall_pct = 0;
    int               hold_len = 0;
    int               hold_id = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               px_sent = 0;
    int               err_count = 0;
    int               cycle_count = 0;

    // Out-of-range sizes behave as the nearest legal size
    function automatic int fit_size(input int v, input int maxv);
        if (v < dmgs_pkg::MIN_SIZE)
        begin
            return dmgs_pkg::MIN_SIZE;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return v;
    endfunction

    function automatic void restart_frame();
        col_pos    = 0;
        row_pos    = fit_size(height_reg, MAX_H) - 1;
        mark_lo    = 0;
        mark_hi    = 0;
        row_marked = 1'b0;
        span_max   = -1;
        span_left  = -1;
        span_right = -1;
        band_open  = -1;
        band_close = -1;
        start_seen = 1'b0;
        end_seen   = 1'b0;
        start_col  = 0;
        start_row  = 0;
        end_col    = 0;
        end_row    = 0;
    endfunction

    // Fold a finished row into the widest-span tracking
    function automatic void close_row(input int w, input int row);
        int left;
        int right;
        int span;
        if (row_marked)
        begin
            left  = mark_lo;
            right = mark_hi;
        end
        else
        begin
            // empty row: centered pseudo span, 0 for odd width, -1 for even
            left  = w / 2;
            right = w - 1 - left;
        end
        span = right - left;
        if (span_max <= span)
        begin
            if (span_max != span)
            begin
                band_open = row;
            end
            band_close = row;
            span_max   = span;
            span_left  = left;
            span_right = right;
        end
    endfunction

    // Advance the predictor by one accepted pixel; queue the frame result
    function automatic void scan_pixel(input logic [dmgs_pkg::PIX_W-1:0] px);
        int                w;
        int                mid;
        int                j;
        int                i;
        int                cx;
        int                cy;
        bit                ok;
        dmgs_pkg::result_t r;
        w   = fit_size(width_reg, MAX_W);
        mid = w / 2;
        j   = col_pos;
        i   = row_pos;
        // row 0 is taken in but never marks anything
        if (i > 0)
        begin
            if (px == dmgs_pkg::PIX_MARK)
            begin
                if (j < mid && !start_seen)
                begin
                    start_seen = 1'b1;
                    start_col  = j;
                    start_row  = i;
                end
                if (j > mid && !end_seen)
                begin
                    end_seen = 1'b1;
                    end_col  = j;
                    end_row  = i;
                end
            end
            if (px != dmgs_pkg::PIX_EMPTY)
            begin
                if (!row_marked)
                begin
                    mark_lo = j;
                end
                mark_hi    = j;
                row_marked = 1'b1;
            end
        end
        if (j + 1 < w)
        begin
            col_pos = j + 1;
            return;
        end
        if (i > 0)
        begin
            close_row(w, i);
            row_pos    = i - 1;
            col_pos    = 0;
            row_marked = 1'b0;
            mark_lo    = 0;
            mark_hi    = 0;
            return;
        end
        // last pixel of the frame: build the result and start over
        ok = start_seen && end_seen && start_col > 0 && end_col > 0;
        cx = (span_left + span_right) / 2;
        cy = (band_close + band_open) / 2;
        if (cx < 0)
        begin
            cx = 0;
        end
        if (cy < 0)
        begin
            cy = 0;
        end
        r.start_x    = ok ? start_col[dmgs_pkg::OUT_W-1:0] : '0;
        r.start_y    = ok ? start_row[dmgs_pkg::OUT_W-1:0] : '0;
        r.end_x      = ok ? end_col[dmgs_pkg::OUT_W-1:0] : '0;
        r.end_y      = ok ? end_row[dmgs_pkg::OUT_W-1:0] : '0;
        r.ends_found = ok;
        r.center_x   = cx[dmgs_pkg::OUT_W-1:0];
        r.center_y   = cy[dmgs_pkg::OUT_W-1:0];
        frames_due.push_back(r);
        restart_frame();
    endfunction

    // ------------------------------------------------------------------
    // Run limit: end the run if the block hangs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run limit reached, %0d frame results outstanding",
                     $time, frames_due.size());
            $display("dial_mask_geometry_scan_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: drive ready at the falling edge. A hold-off request
    // from a test is counted down here, cycle by cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_seen != hold_id)
        begin
            hold_seen = hold_id;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        end
    endtask

    // Compare every result transaction against the oldest prediction
    always @(posedge clk)
    begin
        dmgs_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frames_due.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected frame result, expected none, actual %0d %0d",
                             $time, center_x, center_y);
                end
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("start_x", want.start_x, start_x);
                check_field("start_y", want.start_y, start_y);
                check_field("end_x", want.end_x, end_x);
                check_field("end_y", want.end_y, end_y);
                check_field("ends_found", want.ends_found, ends_found);
                check_field("center_x", want.center_x, center_x);
                check_field("center_y", want.center_y, center_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel and register drivers; all of them start and end at a falling edge
    // ------------------------------------------------------------------
    task automatic set_idling(input int in_pct, input int out_pct);
        in_gap_pct    = in_pct;
        out_stall_pct = out_pct;
    endtask

    // Offer one pixel, hold it until the transaction, then predict
    task automatic send_pixel(input logic [dmgs_pkg::PIX_W-1:0] px);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do
            @(posedge clk);
        while (!in_ready);
        scan_pixel(px);
        px_sent++;
        @(negedge clk);
    endtask

    // Leaves cfg_valid high so that writes can go back to back; drop any
    // pixel still offered so it is not taken a second time
    task automatic write_reg(input logic [dmgs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dmgs_pkg::CFG_W-1:0] data);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == dmgs_pkg::REG_FRAME_WIDTH)
        begin
            width_reg = data;
            restart_frame();
        end
        else if (idx == dmgs_pkg::REG_FRAME_HEIGHT)
        begin
            height_reg = data;
            restart_frame();
        end
        @(negedge clk);
    endtask

    task automatic write_size(input logic [dmgs_pkg::CFG_W-1:0] w,
                              input logic [dmgs_pkg::CFG_W-1:0] h);
        write_reg(dmgs_pkg::REG_FRAME_WIDTH, w);
        write_reg(dmgs_pkg::REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [dmgs_pkg::PIX_W-1:0] random_pixel(input int density);
        if ($urandom_range(99) >= density)
        begin
            return dmgs_pkg::PIX_EMPTY;
        end
        case ($urandom_range(3))
            0, 1:    return dmgs_pkg::PIX_MARK;
            2:       return pix_t'($urandom_range(254, 1));
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    // style 0: scattered marks; style 1: one contiguous run per row, like a dial
    task automatic send_frame(input int w, input int h, input int style, input int density);
        int                         lo;
        int                         hi;
        bit                         blank;
        logic [dmgs_pkg::PIX_W-1:0] px;
        for (int r = 0; r < h; r++)
        begin
            lo    = $urandom_range(w - 1);
            hi    = $urandom_range(w - 1, lo);
            blank = ($urandom_range(4) == 0);
            for (int c = 0; c < w; c++)
            begin
                if (style == 0)
                begin
                    px = random_pixel(density);
                end
                else if (!blank && c >= lo && c <= hi)
                begin
                    px = ($urandom_range(3) == 0) ? pix_t'($urandom_range(254, 1))
                                                  : dmgs_pkg::PIX_MARK;
                end
                else
                begin
                    px = ($urandom_range(19) == 0) ? pix_t'($urandom_range(255))
                                                   : dmgs_pkg::PIX_EMPTY;
                end
                send_pixel(px);
            end
        end
    endtask

    // Top row carries marks just left of middle and at the far right column
    task automatic send_marked_frame(input int w, input int h, input int density);
        for (int c = 0; c < w; c++)
        begin
            send_pixel((c == w / 2 - 1 || c == w - 1) ? dmgs_pkg::PIX_MARK
                                                      : dmgs_pkg::PIX_EMPTY);
        end
        for (int n = w; n < w * h; n++)
        begin
            send_pixel(random_pixel(density));
        end
    endtask

    task automatic send_partial(input int count);
        repeat (count) send_pixel(random_pixel(40));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Writes mid-frame: real registers restart the frame, spare indexes do not
    task automatic test_frame_restart();
        set_idling(0, 0);
        // a few pixels of the reset-size frame, then drop it
        send_partial(6);
        quiesce();
        write_size(6, 3);
        send_partial(8);
        quiesce();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, cfg_word_t'($urandom_range(2047)));
        cfg_valid <= 1'b0;
        // finish the interrupted frame: the spare writes must not disturb it
        send_partial(10);
        quiesce();
        send_partial(7);
        quiesce();
        write_reg(dmgs_pkg::REG_FRAME_HEIGHT, 4);
        cfg_valid <= 1'b0;
        send_frame(6, 4, 1, 50);
        quiesce();
    endtask

    // Hand-made frames: start at column zero, middle column, row 0 ignored,
    // single mark, empty rows, and sizes below the minimum
    task automatic test_directed();
        logic [dmgs_pkg::PIX_W-1:0] frame_a[4]  = '{dmgs_pkg::PIX_MARK, dmgs_pkg::PIX_MARK,
                                                    dmgs_pkg::PIX_EMPTY, dmgs_pkg::PIX_EMPTY};
        logic [dmgs_pkg::PIX_W-1:0] frame_b[10] = '{dmgs_pkg::PIX_EMPTY, dmgs_pkg::PIX_MARK,
                                                    dmgs_pkg::PIX_MARK, dmgs_pkg::PIX_MARK,
                                                    8'd7, dmgs_pkg::PIX_MARK,
                                                    dmgs_pkg::PIX_MARK, dmgs_pkg::PIX_MARK,
                                                    dmgs_pkg::PIX_MARK, dmgs_pkg::PIX_MARK};
        logic [dmgs_pkg::PIX_W-1:0] frame_c[9]  = '{dmgs_pkg::PIX_EMPTY, dmgs_pkg::PIX_EMPTY,
                                                    dmgs_pkg::PIX_EMPTY, dmgs_pkg::PIX_EMPTY,
                                                    8'd200, dmgs_pkg::PIX_EMPTY,
                                                    dmgs_pkg::PIX_EMPTY, 8'd128,
                                                    dmgs_pkg::PIX_EMPTY};
        set_idling(0, 0);
        write_size(1, 0);
        foreach (frame_a[k])
        begin
            send_pixel(frame_a[k]);
        end
        write_size(5, 2);
        foreach (frame_b[k])
        begin
            send_pixel(frame_b[k]);
        end
        write_size(3, 3);
        foreach (frame_c[k])
        begin
            send_pixel(frame_c[k]);
        end
        quiesce();
    endtask

    // A wide frame and a tall frame, one each
    task automatic test_size_extremes();
        set_idling(0, 0);
        write_size(200, 2);
        send_marked_frame(200, 2, 3);
        quiesce();
        write_size(4, 60);
        send_marked_frame(4, 60, 10);
        quiesce();
    endtask

    // Hold off results for a long stretch while pixels keep coming, so the
    // block backs up and stalls its input
    task automatic test_output_holdoff();
        set_idling(0, 0);
        write_size(2, 2);
        hold_len = 300;
        hold_id++;
        repeat (40) send_frame(2, 2, $urandom_range(1), 60);
        quiesce();
    endtask

    // Random sizes and content under each idling pattern; some groups end
    // in a partial frame that the next size write throws away
    task automatic test_random_frames();
        int base;
        int w;
        int h;
        int fw;
        int fh;
        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:       set_idling(0, 0);
                1:       set_idling(66, 0);
                2:       set_idling(0, 66);
                default: set_idling(6, 6);
            endcase
            base = px_sent;
            while (px_sent - base < PHASE_PIXELS)
            begin
                w = ($urandom_range(7) == 0) ? $urandom_range(40, 2) : $urandom_range(8, 2);
                h = ($urandom_range(7) == 0) ? $urandom_range(12, 2) : $urandom_range(6, 2);
                if ($urandom_range(15) == 0)
                begin
                    w = $urandom_range(1);
                end
                if ($urandom_range(15) == 0)
                begin
                    h = $urandom_range(1);
                end
                fw = fit_size(w, MAX_W);
                fh = fit_size(h, MAX_H);
                quiesce();
                write_size(cfg_word_t'(w), cfg_word_t'(h));
                repeat ($urandom_range(4, 1))
                begin
                    send_frame(fw, fh, $urandom_range(1), $urandom_range(80, 10));
                end
                if ($urandom_range(5) == 0)
                begin
                    send_partial($urandom_range(fw * fh - 1, 1));
                end
            end
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel     = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = dmgs_pkg::REG_FRAME_WIDTH;
        cfg_data  = '0;
        width_reg  = cfg_word_t'(dmgs_pkg::RESET_WIDTH);
        height_reg = cfg_word_t'(dmgs_pkg::RESET_HEIGHT);
        restart_frame();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_frame_restart();
        test_directed();
        test_size_extremes();
        test_output_holdoff();
        test_random_frames();

        if (err_count == 0)
        begin
            $display("dial_mask_geometry_scan_core verification clean");
        end
        else
        begin
            $display("dial_mask_geometry_scan_core verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dmgs_pkg.sv
hdl/dmgs_cfg.sv
hdl/dmgs_scan.sv
hdl/dial_mask_geometry_scan_core.sv
verif/dial_mask_geometry_scan_core_tb.sv
